// ===== sv/gmlp_pkg.sv =====
// ----------------------------------------------------------------------------
// G-code line parser package
// Shared payload types and command codes.
// ----------------------------------------------------------------------------
package gmlp_pkg;

	typedef enum logic [1:0] {
		CMD_LINEAR = 2'd0,
		CMD_ARC_CW = 2'd1,
		CMD_ARC_CCW = 2'd2,
		CMD_HOME = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [7:0] ch;
		logic line_end;
		logic signed [31:0] current_x;
		logic signed [31:0] current_y;
		logic signed [31:0] current_feed;
	} in_item_t;

	typedef struct packed {
		logic [1:0] command;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] center_i;
		logic signed [31:0] center_j;
		logic signed [31:0] feed;
	} out_item_t;

	// Classified character handed from the front part to the back part.
	typedef struct packed {
		logic [7:0] ch;
		logic line_end;
		logic is_space;
		logic is_digit;
		logic is_sign;
		logic is_point;
		logic is_ws;
		logic [3:0] digit;
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
		logic signed [31:0] cur_f;
	} cls_item_t;

	localparam logic [7:0] CH_G_UP = 8'h47;
	localparam logic [7:0] CH_G_LO = 8'h67;
	localparam logic [7:0] CH_X = 8'h58;
	localparam logic [7:0] CH_Y = 8'h59;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_J = 8'h4A;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam int HOME_CODE = 28;

endpackage

// ===== sv/gcode_motion_line_parser.sv =====
// ----------------------------------------------------------------------------
// G-code motion line parser
// Turns a stream of G-code characters into motion commands, at most one per line.
// ----------------------------------------------------------------------------
// The block takes one character per transfer and, when a transfer marks the end of
// a line, delivers at most one motion command on its result side. A character is
// taken every clock cycle while the block is not full; the rate is set by the
// per-character accumulate step in the back part, which handles one character per
// cycle unless a result waits unpopped. A character is registered in the
// classifying front stage, then passes a two-entry queue to the back part, and a
// command is registered when the back part takes its line end. One finished command
// is held in the output register as more characters flow in until the queue fills.
module gcode_motion_line_parser #(
	parameter int FRACTION_DIGITS = 3,
	parameter int VALUE_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input gmlp_pkg::in_item_t in_item,
	input logic push,
	output logic full,
	output gmlp_pkg::out_item_t out_item,
	output logic empty,
	input logic pop
);
	import gmlp_pkg::*;

	cls_item_t front_data, back_data;
	logic front_valid, front_ready, back_valid, back_ready;
	logic in_ready;

	// The front stage classifies each character.
	gmlp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_item), .in_valid(push), .in_ready(in_ready),
		.out_data(front_data), .out_valid(front_valid), .out_ready(front_ready)
	);

	assign full = !in_ready;

	// The queue lets the front keep accepting while a result waits to be popped.
	gmlp_fifo #(.DEPTH(2), .WIDTH($bits(cls_item_t))) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_data(front_data), .wr_valid(front_valid), .wr_ready(front_ready),
		.rd_data(back_data), .rd_valid(back_valid), .rd_ready(back_ready)
	);

	// The back part runs the parse state and holds the result register.
	gmlp_back #(.FRACTION_DIGITS(FRACTION_DIGITS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_data(back_data), .in_valid(back_valid), .in_ready(back_ready),
		.out_data(out_item), .out_empty(empty), .out_pop(pop)
	);

	// A held result must not change until it is popped.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("result changed while waiting");

	// The back part takes nothing while a result waits and is not popped.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |-> !back_ready)
		else $error("back part ready while a result is held");

	// With the queue full, the input side must stall.
	assert property (@(posedge clk) disable iff (!arst_n)
		front_valid && !front_ready |-> full)
		else $error("input accepted while queue full");
endmodule

// ===== sv/gmlp_front.sv =====
// ----------------------------------------------------------------------------
// G-code line parser front part
// Accepts characters and classifies them into a registered stage.
// ----------------------------------------------------------------------------
module gmlp_front (
	input logic clk,
	input logic arst_n,
	input gmlp_pkg::in_item_t in_data,
	input logic in_valid,
	output logic in_ready,
	output gmlp_pkg::cls_item_t out_data,
	output logic out_valid,
	input logic out_ready
);
	import gmlp_pkg::*;

	cls_item_t cls;
	logic valid_s1;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		cls.ch = in_data.ch;
		cls.line_end = in_data.line_end;
		cls.is_space = in_data.ch == CH_SPACE;
		cls.is_digit = in_data.ch >= CH_ZERO && in_data.ch <= CH_NINE;
		cls.is_sign = in_data.ch == CH_PLUS || in_data.ch == CH_MINUS;
		cls.is_point = in_data.ch == CH_POINT;
		cls.is_ws = in_data.ch >= CH_TAB && in_data.ch <= CH_CR;
		cls.digit = 4'(in_data.ch - CH_ZERO);
		cls.cur_x = in_data.current_x;
		cls.cur_y = in_data.current_y;
		cls.cur_f = in_data.current_feed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_data <= cls;
		end
	end

	assign out_valid = valid_s1;
endmodule

// ===== sv/gmlp_fifo.sv =====
// ----------------------------------------------------------------------------
// G-code line parser queue
// Small queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
module gmlp_fifo #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8
) (
	input logic clk,
	input logic arst_n,
	input logic [WIDTH-1:0] wr_data,
	input logic wr_valid,
	output logic wr_ready,
	output logic [WIDTH-1:0] rd_data,
	output logic rd_valid,
	input logic rd_ready
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end
endmodule

// ===== sv/gmlp_back.sv =====
// ----------------------------------------------------------------------------
// G-code line parser back part
// Runs the word and number state machine and builds at most one command per line.
// ----------------------------------------------------------------------------
module gmlp_back #(
	parameter int FRACTION_DIGITS = 3,
	parameter int VALUE_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input gmlp_pkg::cls_item_t in_data,
	input logic in_valid,
	output logic in_ready,
	output gmlp_pkg::out_item_t out_data,
	output logic out_empty,
	input logic out_pop
);
	import gmlp_pkg::*;

	localparam int AW = VALUE_WIDTH + 1;
	localparam logic [AW-1:0] CAP = AW'(1) << (VALUE_WIDTH - 1);
	localparam int FCW = 3;

	typedef enum logic [1:0] {
		PH_SEEK, PH_CODE, PH_ARGS, PH_NUM
	} phase_t;

	phase_t phase_q;
	logic word_start_q;
	logic signed [9:0] code_q;
	logic [1:0] cps_q;
	logic [7:0] letter_q;
	logic [AW-1:0] acc_q;
	logic neg_q, point_q, any_q, stop_q;
	logic [FCW-1:0] fcnt_q;
	// Only the low 32 bits of each stored value ever reach the outputs.
	logic [31:0] fx_q, fy_q, fi_q, fj_q, ff_q;
	logic [2:0] pres_q;
	logic full_q;
	out_item_t res_q;

	// Number finishing: scale up missing fraction digits, then clamp and sign.
	logic [AW-1:0] scaled;
	logic [VALUE_WIDTH-1:0] fin_val;
	logic [AW+3:0] mul10;

	always_comb begin
		scaled = acc_q;
		for (int k = 0; k < 6; k++) begin
			mul10 = {4'b0, scaled} * (AW+4)'(10);
			if (k < FRACTION_DIGITS && FCW'(k) >= fcnt_q) begin
				scaled = (mul10 > (AW+4)'(CAP)) ? CAP : mul10[AW-1:0];
			end
		end
		if (!neg_q && scaled > CAP - 1'b1) begin
			scaled = CAP - 1'b1;
		end
		fin_val = neg_q ? VALUE_WIDTH'(-scaled) : scaled[VALUE_WIDTH-1:0];
	end

	logic take, finish, emit;
	logic [AW+3:0] acc_next;
	logic signed [13:0] code_next;
	logic [31:0] vx, vy, vi, vj, vf;

	assign in_ready = !full_q || out_pop;
	assign take = in_valid && in_ready;
	assign acc_next = {4'b0, acc_q} * (AW+4)'(10) + (AW+4)'(in_data.digit);
	assign code_next = (cps_q == 2'd2) ? 14'(code_q) * 14'sd10 - 14'(in_data.digit)
		: 14'(code_q) * 14'sd10 + 14'(in_data.digit);

	always_comb begin
		finish = 1'b0;
		if (in_data.line_end) begin
			finish = phase_q == PH_NUM;
		end else if (phase_q == PH_NUM) begin
			finish = !(in_data.is_digit || in_data.is_point || in_data.is_sign);
		end
	end

	// Values including a number that this character finishes, also one still open at line end.
	always_comb begin
		vx = fx_q;
		vy = fy_q;
		vi = fi_q;
		vj = fj_q;
		vf = ff_q;
		if (finish) begin
			case (letter_q)
				CH_X: vx = 32'(signed'(fin_val));
				CH_Y: vy = 32'(signed'(fin_val));
				CH_I: vi = 32'(signed'(fin_val));
				CH_J: vj = 32'(signed'(fin_val));
				CH_F: vf = 32'(signed'(fin_val));
				default: ;
			endcase
		end
	end

	logic [2:0] pres_end;
	always_comb begin
		pres_end = pres_q;
		if (finish) begin
			case (letter_q)
				CH_X: pres_end[0] = 1'b1;
				CH_Y: pres_end[1] = 1'b1;
				CH_F: pres_end[2] = 1'b1;
				default: ;
			endcase
		end
	end

	assign emit = in_data.line_end && phase_q != PH_SEEK && (code_q == 10'sd0
		|| code_q == 10'sd1 || code_q == 10'sd2 || code_q == 10'sd3
		|| code_q == 10'(HOME_CODE));

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q.center_i <= '0;
			res_q.center_j <= '0;
			res_q.feed <= pres_end[2] ? vf : in_data.cur_f;
			if (code_q == 10'sd0 || code_q == 10'sd1) begin
				res_q.command <= CMD_LINEAR;
				res_q.target_x <= pres_end[0] ? vx : in_data.cur_x;
				res_q.target_y <= pres_end[1] ? vy : in_data.cur_y;
			end else if (code_q == 10'sd2 || code_q == 10'sd3) begin
				res_q.command <= (code_q == 10'sd2) ? CMD_ARC_CW : CMD_ARC_CCW;
				res_q.target_x <= vx;
				res_q.target_y <= vy;
				res_q.center_i <= vi;
				res_q.center_j <= vj;
			end else begin
				res_q.command <= CMD_HOME;
				res_q.target_x <= '0;
				res_q.target_y <= '0;
				res_q.feed <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			phase_q <= PH_SEEK;
			word_start_q <= 1'b1;
			code_q <= '0;
			cps_q <= '0;
			letter_q <= '0;
			acc_q <= '0;
			{neg_q, point_q, any_q, stop_q} <= '0;
			fcnt_q <= '0;
			{fx_q, fy_q, fi_q, fj_q, ff_q} <= '0;
			pres_q <= '0;
		end else begin
			if (out_pop && full_q) begin
				full_q <= 1'b0;
			end
			if (take && emit) begin
				full_q <= 1'b1;
			end
			if (take) begin
				if (in_data.line_end) begin
					phase_q <= PH_SEEK;
					word_start_q <= 1'b1;
					code_q <= '0;
					cps_q <= '0;
					letter_q <= '0;
					acc_q <= '0;
					{neg_q, point_q, any_q, stop_q} <= '0;
					fcnt_q <= '0;
					{fx_q, fy_q, fi_q, fj_q, ff_q} <= '0;
					pres_q <= '0;
				end else begin
					case (phase_q)
						PH_SEEK: begin
							if (word_start_q) begin
								if (in_data.ch == CH_G_UP || in_data.ch == CH_G_LO) begin
									phase_q <= PH_CODE;
									word_start_q <= 1'b0;
								end else if (!in_data.is_space) begin
									word_start_q <= 1'b0;
								end
							end else if (in_data.is_space) begin
								word_start_q <= 1'b1;
							end
						end
						PH_CODE: begin
							if (in_data.is_space) begin
								phase_q <= PH_ARGS;
							end else if (cps_q == 2'd0 && in_data.is_ws) begin
								cps_q <= cps_q;
							end else if (cps_q == 2'd0 && in_data.is_sign) begin
								cps_q <= (in_data.ch == CH_MINUS) ? 2'd2 : 2'd1;
							end else if (cps_q != 2'd3) begin
								if (!in_data.is_digit) begin
									cps_q <= 2'd3;
								end else begin
									if (cps_q == 2'd0) begin
										cps_q <= 2'd1;
									end
									if (code_next > 14'sd255) begin
										code_q <= 10'sd255;
									end else if (code_next < -14'sd256) begin
										code_q <= -10'sd256;
									end else begin
										code_q <= 10'(code_next);
									end
								end
							end
						end
						default: begin
							if (phase_q == PH_NUM && !finish) begin
								if (!stop_q) begin
									any_q <= 1'b1;
									if (in_data.is_sign) begin
										if (any_q) begin
											stop_q <= 1'b1;
										end else if (in_data.ch == CH_MINUS) begin
											neg_q <= 1'b1;
										end
									end else if (in_data.is_point) begin
										if (point_q) begin
											stop_q <= 1'b1;
										end else begin
											point_q <= 1'b1;
										end
									end else if (!point_q
										|| fcnt_q < FCW'(FRACTION_DIGITS)) begin
										if (point_q) begin
											fcnt_q <= fcnt_q + 1'b1;
										end
										acc_q <= (acc_next > (AW+4)'(CAP)) ? CAP
											: acc_next[AW-1:0];
									end
								end
							end else begin
								if (finish) begin
									fx_q <= vx;
									fy_q <= vy;
									fi_q <= vi;
									fj_q <= vj;
									ff_q <= vf;
									pres_q <= pres_end;
								end
								if (!in_data.is_space) begin
									letter_q <= in_data.ch;
									acc_q <= '0;
									{neg_q, point_q, any_q, stop_q} <= '0;
									fcnt_q <= '0;
									phase_q <= PH_NUM;
								end else begin
									phase_q <= PH_ARGS;
								end
							end
						end
					endcase
				end
			end
		end
	end

	assign out_data = res_q;
	assign out_empty = !full_q;
endmodule
